/* rtl/audio_looper_overdub_delay_line_defines.svh */
// ---------------------------------------------------------------------------
// Looper delay line assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef AUDIO_LOOPER_OVERDUB_DELAY_LINE_DEFINES_SVH
`define AUDIO_LOOPER_OVERDUB_DELAY_LINE_DEFINES_SVH

// Same-cycle implication.
`define ALOD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALOD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/alod_pkg.sv */
// ---------------------------------------------------------------------------
// Looper delay line package
// Sizes, register codes, mode codes, state type and saturating add.
// ---------------------------------------------------------------------------
`default_nettype none

package alod_pkg;

    localparam int STORE_DEPTH = 131072;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = 2 * SAMPLE_BITS;
    localparam int LEN_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int DLY_W       = (LEN_W > ADDR_W) ? LEN_W : ADDR_W;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_W-1:0]             addr_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 2'd2;

    // Mode codes; the fourth code neither records nor plays back
    localparam logic [1:0] MODE_RECORD  = 2'd0;
    localparam logic [1:0] MODE_OVERDUB = 2'd1;
    localparam logic [1:0] MODE_PLAY    = 2'd2;

    // Reset values of the registers
    localparam logic             ENABLED_RST     = 1'b1;
    localparam logic [1:0]       MODE_RST        = MODE_RECORD;
    localparam logic [LEN_W-1:0] LOOP_LENGTH_RST = LEN_W'(96000);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Add two samples and clamp to the signed sample range.
    function automatic sample_t sat_add(input sample_t a, input sample_t b);
        logic [SAMPLE_BITS:0] s;
        s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
        if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1])
            return s[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
        return sample_t'(s[SAMPLE_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

/* rtl/audio_looper_overdub_delay_line.sv */
// ---------------------------------------------------------------------------
// Stereo overdub looper delay line
// Circular loop store with record, overdub and playback, saturating sums.
// ---------------------------------------------------------------------------
// Each request carries one stereo frame (or a clear action) and yields exactly
// one result frame. The loop store is a single-port-write, registered-read
// RAM of STORE_DEPTH stereo entries; a frame reads its playback entry at
// acceptance and writes its entry back as it leaves stage 1, so a new frame
// is taken every clock while the output register is drained and no clear is
// pending. When the loop length is one, the playback entry is the one the
// previous frame is writing in that same cycle; that write data is forwarded
// instead of the stale RAM word. A clear request returns a zero frame and
// then sweeps the whole store, one entry per cycle; no request is taken
// during the sweep. The same sweep runs right after reset, so in_ready
// first rises once that sweep is over. Configuration writes are taken at any
// time and are meant to change only while the block is idle. Disabled frames
// pass straight through without touching the store or the write position.
// ---------------------------------------------------------------------------
`default_nettype none

module audio_looper_overdub_delay_line (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [alod_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [alod_pkg::LEN_W-1:0]          cfg_data,
    // input request channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic signed [alod_pkg::SAMPLE_BITS-1:0] in_left,
    input  wire logic signed [alod_pkg::SAMPLE_BITS-1:0] in_right,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [alod_pkg::SAMPLE_BITS-1:0]  out_left,
    output logic signed [alod_pkg::SAMPLE_BITS-1:0]  out_right
);

    import alod_pkg::*;

`include "audio_looper_overdub_delay_line_defines.svh"

    localparam addr_t               ADDR_LAST  = addr_t'(STORE_DEPTH - 1);
    localparam logic [DLY_W-1:0]    DELAY_MAX  = DLY_W'(STORE_DEPTH - 1);
    localparam logic [ADDR_W:0]     DEPTH_WIDE = (ADDR_W + 1)'(STORE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             enabled_reg;
    logic [1:0]       mode_reg;
    logic [LEN_W-1:0] loop_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= ENABLED_RST;
            mode_reg        <= MODE_RST;
            loop_length_reg <= LOOP_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ENABLED:     enabled_reg     <= cfg_data[0];
                REG_MODE:        mode_reg        <= cfg_data[1:0];
                REG_LOOP_LENGTH: loop_length_reg <= cfg_data;
                default:         ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state: clear sweep versus normal run
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    addr_t  sweep_cnt_reg;

    // Stage 1: accepted request waiting for its RAM read
    logic    s1_valid_reg;
    logic    s1_clear_reg;
    logic    s1_proc_reg;
    logic    s1_rec_reg;
    logic    s1_loop_reg;
    addr_t   s1_pos_reg;
    sample_t s1_left_reg;
    sample_t s1_right_reg;

    // Forwarding of a write that overlapped the read
    logic               fwd_valid_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    // Output register
    logic    out_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;

    addr_t pos_reg;

    logic in_accept;
    logic s1_adv;
    logic sweep_we;
    logic sweep_done;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_accept  = in_valid && in_ready;
    assign sweep_done = (sweep_cnt_reg == ADDR_LAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (sweep_done) state_next = ST_RUN;
            ST_RUN:   if (s1_adv && s1_clear_reg) state_next = ST_CLEAR;
            default:  state_next = ST_RUN;
        endcase
    end

    // State outputs: sweep writes and request acceptance
    always_comb
    begin
        sweep_we = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: sweep_we = 1'b1;
            ST_RUN:   in_ready = !(s1_valid_reg && s1_clear_reg)
                                 && (!s1_valid_reg || s1_adv);
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                sweep_cnt_reg <= sweep_done ? '0 : sweep_cnt_reg + addr_t'(1);
        end
    end

    // ------------------------------------------------------------------
    // Playback address: write position minus capped loop length, wrapped
    // ------------------------------------------------------------------
    logic [DLY_W-1:0] len_wide;
    addr_t            delay;
    logic [ADDR_W:0]  rd_diff;
    addr_t            rd_addr;
    logic             in_proc;

    always_comb
    begin
        len_wide = DLY_W'(loop_length_reg);
        delay    = (len_wide > DELAY_MAX) ? ADDR_LAST : len_wide[ADDR_W-1:0];
        rd_diff  = {1'b0, pos_reg} - {1'b0, delay};
        if (rd_diff[ADDR_W])
            rd_diff = rd_diff + DEPTH_WIDE;
        rd_addr  = rd_diff[ADDR_W-1:0];
        in_proc  = enabled_reg && !action;
    end

    // Advance the write position on every processed frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (in_accept && in_proc)
            pos_reg <= (pos_reg == ADDR_LAST) ? '0 : pos_reg + addr_t'(1);
    end

    // ------------------------------------------------------------------
    // Loop store RAM
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] mem [STORE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_we;
    addr_t              mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (in_accept)
            rdata_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Stage 1 capture
    // ------------------------------------------------------------------
    logic comp_we;
    logic fwd_hit;

    assign fwd_hit = comp_we && (s1_pos_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg  <= 1'b1;
            fwd_valid_reg <= fwd_hit;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_clear_reg <= action;
            s1_proc_reg  <= in_proc;
            s1_rec_reg   <= (mode_reg == MODE_RECORD) || (mode_reg == MODE_OVERDUB);
            s1_loop_reg  <= (mode_reg == MODE_OVERDUB) || (mode_reg == MODE_PLAY);
            s1_pos_reg   <= pos_reg;
            s1_left_reg  <= in_left;
            s1_right_reg <= in_right;
            fwd_data_reg <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Read-modify-write: mix playback, write back, load the output
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] play_word;
    sample_t            play_left;
    sample_t            play_right;
    sample_t            wr_left;
    sample_t            wr_right;
    sample_t            res_left;
    sample_t            res_right;

    always_comb
    begin
        play_word  = fwd_valid_reg ? fwd_data_reg : rdata_reg;
        play_left  = sample_t'(play_word[ENTRY_W-1:SAMPLE_BITS]);
        play_right = sample_t'(play_word[SAMPLE_BITS-1:0]);

        wr_left   = s1_rec_reg ? s1_left_reg  : '0;
        wr_right  = s1_rec_reg ? s1_right_reg : '0;
        res_left  = s1_left_reg;
        res_right = s1_right_reg;
        if (s1_loop_reg)
        begin
            wr_left   = sat_add(wr_left,  play_left);
            wr_right  = sat_add(wr_right, play_right);
            res_left  = sat_add(s1_left_reg,  play_left);
            res_right = sat_add(s1_right_reg, play_right);
        end
        if (s1_clear_reg)
        begin
            res_left  = '0;
            res_right = '0;
        end
        else if (!s1_proc_reg)
        begin
            res_left  = s1_left_reg;
            res_right = s1_right_reg;
        end

        comp_we = s1_adv && s1_proc_reg && !s1_clear_reg;

        // Sweep and frame writes never overlap: stage 1 is empty while clearing
        mem_we    = sweep_we || comp_we;
        mem_waddr = sweep_we ? sweep_cnt_reg : s1_pos_reg;
        mem_wdata = sweep_we ? '0 : {wr_left, wr_right};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_left_reg  <= res_left;
            out_right_reg <= res_right;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ALOD_ASSERT_IMP(a_no_accept_in_sweep, state_reg == ST_CLEAR, !in_ready,
        "request accepted during clear sweep")
    `ALOD_ASSERT_IMP(a_s1_empty_in_sweep, state_reg == ST_CLEAR, !s1_valid_reg,
        "frame pending while the store is being cleared")
    `ALOD_ASSERT_IMP(a_hold_behind_clear, s1_valid_reg && s1_clear_reg, !in_ready,
        "request accepted behind a pending clear")
    `ALOD_ASSERT_NXT(a_sweep_ends, state_reg == ST_CLEAR && sweep_done,
        state_reg == ST_RUN && sweep_cnt_reg == '0,
        "clear sweep did not finish after the last entry")

endmodule

`default_nettype wire

/* bench/audio_looper_overdub_delay_line_tb.sv */
// ---------------------------------------------------------------------------
// Looper delay line testbench
// Drives stereo frame requests and clear actions into the looper under
// random handshake pressure. A shadow loop store predicts every result
// frame, and each returned frame is checked against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module audio_looper_overdub_delay_line_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import alod_pkg::*;

    // The package names three mode codes; the fourth one mutes the store.
    localparam logic [1:0] MODE_MUTE = 2'd3;

    // Each clear sweeps the whole store with no request taken, so a quiet
    // stretch must outlast one sweep plus the longest receiver hold-off.
    localparam int STALL_LIMIT    = 4 * STORE_DEPTH;
    localparam int PHASES         = 13;
    localparam int FRAMES_PER_SET = 145;
    localparam int HOLD_OFF       = 300;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 action = 1'b0;
    sample_t              in_left = '0;
    sample_t              in_right = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    sample_t              out_left;
    sample_t              out_right;

    // Shadow copy of the looper: store, write pointer and registers.
    sample_t          shadow_left [STORE_DEPTH];
    sample_t          shadow_right[STORE_DEPTH];
    addr_t            shadow_wr_pos = '0;
    logic             cfg_enabled = ENABLED_RST;
    logic [1:0]       cfg_mode = MODE_RST;
    logic [LEN_W-1:0] cfg_len = LOOP_LENGTH_RST;

    // Predicted result frames, oldest first.
    frame_t pending_frames[$];

    int unsigned frames_sent = 0;
    int unsigned clears_sent = 0;
    int unsigned settings_used = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // Shared knobs: no_gaps drops all idling on both sides; hold_cycles asks
    // the receiver for one long hold-off before its next result.
    bit          no_gaps = 1'b0;
    int unsigned hold_cycles = 0;

    audio_looper_overdub_delay_line DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .in_left   (in_left),
        .in_right  (in_right),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_left  (out_left),
        .out_right (out_right)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    function automatic void wipe_shadow();
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            shadow_left[i]  = '0;
            shadow_right[i] = '0;
        end
    endfunction

    // Add two samples and pin the sum to the signed sample range.
    function automatic sample_t clamp_add(input sample_t a, input sample_t b);
        int total;
        total = int'(a) + int'(b);
        if (total > int'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (total < int'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(total);
    endfunction

    // Advance the shadow looper by one request and return the frame it yields.
    function automatic frame_t looper_predict(input logic clear, input sample_t l,
                                              input sample_t r);
        frame_t     res;
        sample_t    keep_l;
        sample_t    keep_r;
        sample_t    play_l;
        sample_t    play_r;
        addr_t      rd_pos;
        int         delay;
        logic       take_input;
        logic       replay;
        res.left  = l;
        res.right = r;
        // Clear zeroes the store but keeps the write pointer, enabled or not.
        if (clear)
        begin
            wipe_shadow();
            res.left  = '0;
            res.right = '0;
            return res;
        end
        // Disabled: pass the input and leave the store alone.
        if (!cfg_enabled)
            return res;
        take_input = (cfg_mode == MODE_RECORD) || (cfg_mode == MODE_OVERDUB);
        replay     = (cfg_mode == MODE_OVERDUB) || (cfg_mode == MODE_PLAY);
        keep_l = take_input ? l : '0;
        keep_r = take_input ? r : '0;
        if (replay)
        begin
            // A zero delay reads the entry about to be overwritten.
            delay  = (int'(cfg_len) > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : int'(cfg_len);
            rd_pos = addr_t'((int'(shadow_wr_pos) - delay + STORE_DEPTH) % STORE_DEPTH);
            play_l = shadow_left[rd_pos];
            play_r = shadow_right[rd_pos];
            keep_l    = clamp_add(keep_l, play_l);
            keep_r    = clamp_add(keep_r, play_r);
            res.left  = clamp_add(l, play_l);
            res.right = clamp_add(r, play_r);
        end
        shadow_left[shadow_wr_pos]  = keep_l;
        shadow_right[shadow_wr_pos] = keep_r;
        shadow_wr_pos = (int'(shadow_wr_pos) == STORE_DEPTH - 1) ? '0
                                                                 : shadow_wr_pos + addr_t'(1);
        return res;
    endfunction

    // Mix of rail values, small values around zero and full-range noise.
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(0, 511)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------

    // Offer one request and hold it until taken. Entered and left just after
    // a falling edge; valid stays high on exit so a back-to-back request
    // needs only one assignment in that time step.
    task automatic send_frame(input logic clear, input sample_t l, input sample_t r);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action   <= clear;
        in_left  <= l;
        in_right <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_frames.push_back(looper_predict(clear, l, r));
        frames_sent++;
        if (clear)
            clears_sent++;
        @(negedge clk);
    endtask

    // Write one register once every result is back and any clear sweep is
    // over (in_ready high again), then mirror it in the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0 || !in_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ENABLED:     cfg_enabled = val[0];
            REG_MODE:        cfg_mode    = val[1:0];
            REG_LOOP_LENGTH: cfg_len     = val;
            default:         ;
        endcase
    endtask

    task automatic set_looper(input logic en, input logic [1:0] md, input logic [LEN_W-1:0] len);
        write_reg(REG_ENABLED, LEN_W'(en));
        write_reg(REG_MODE, LEN_W'(md));
        write_reg(REG_LOOP_LENGTH, len);
        settings_used++;
    endtask

    // -----------------------------------------------------------------------
    // Result side: draw a stall per result, take it, check it
    // -----------------------------------------------------------------------

    initial
    begin : result_checker
        int unsigned stall;
        frame_t      want;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            // A requested hold-off overrides the draw and is counted here.
            if (hold_cycles != 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result L=%0d R=%0d",
                             $realtime, out_left, out_right);
            end
            else
            begin
                want = pending_frames.pop_front();
                results_checked++;
                if (out_left !== want.left || out_right !== want.right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 $realtime, results_checked, want.left, want.right,
                                 out_left, out_right);
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset values: enabled, record mode. The first request waits out the
    // post-reset clearing sweep.
    task automatic test_reset_defaults();
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
        send_frame(1'b0, '0, sample_t'(-1));
        send_frame(1'b0, sample_t'(24'h555555), sample_t'(24'hAAAAAA));
    endtask

    // Length one reads the frame written just before, through the forward
    // path when back to back. Rail values drive both saturation directions.
    task automatic test_overdub_saturation();
        set_looper(1'b1, MODE_OVERDUB, LEN_W'(1));
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
        set_looper(1'b1, MODE_PLAY, LEN_W'(1));
        send_frame(1'b0, SAMPLE_MAX, sample_t'(-1));
        send_frame(1'b0, sample_t'(24'hAAAAAA), sample_t'(24'h555555));
    endtask

    // Muted mode code, zero loop length and the longest loop length.
    task automatic test_odd_settings();
        set_looper(1'b1, MODE_MUTE, LEN_W'(5));
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, sample_t'(1), sample_t'(-1));
        set_looper(1'b1, MODE_OVERDUB, '0);
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
        send_frame(1'b0, sample_t'(7), sample_t'(-7));
        set_looper(1'b1, MODE_PLAY, '1);
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MAX);
    endtask

    // Pass-through while disabled, a clear while disabled, then a clear
    // while enabled after some playback of the wiped store.
    task automatic test_disable_and_clear();
        set_looper(1'b0, MODE_PLAY, LEN_W'(2));
        send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
        send_frame(1'b0, sample_t'(-1), '0);
        send_frame(1'b1, SAMPLE_MAX, SAMPLE_MAX);
        set_looper(1'b1, MODE_OVERDUB, LEN_W'(2));
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b0, sample_t'(3), sample_t'(-3));
        send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(1'b1, pick_sample(), pick_sample());
    endtask

    // Hold results off for a long stretch while requests keep coming, so
    // the block fills up and drops in_ready.
    task automatic test_backpressure();
        set_looper(1'b1, MODE_OVERDUB, LEN_W'(3));
        no_gaps     = 1'b1;
        hold_cycles = HOLD_OFF;
        for (int i = 0; i < 40; i++)
            send_frame(1'b0, pick_sample(), pick_sample());
        no_gaps = 1'b0;
    endtask

    // Record, overdub and play phases over a shared loop length, so playback
    // returns what earlier phases laid down. Two phases carry one clear each.
    task automatic test_random_phases();
        logic [LEN_W-1:0] len;
        logic [1:0]       md;
        int               clear_at;
        len = LEN_W'(4);
        for (int p = 0; p < PHASES; p++)
        begin
            if (p % 4 == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       len = LEN_W'(1);
                    1:       len = '0;
                    2:       len = '1;
                    3:       len = LEN_W'($urandom_range(1, 400));
                    default: len = LEN_W'($urandom_range(1, 24));
                endcase
            end
            case (p % 4)
                0:       md = MODE_RECORD;
                1:       md = MODE_OVERDUB;
                2:       md = MODE_PLAY;
                default: md = 2'($urandom_range(0, 3));
            endcase
            set_looper($urandom_range(0, 9) != 0, md, len);
            no_gaps  = ($urandom_range(0, 3) == 0);
            clear_at = (p == 4 || p == 10) ? int'($urandom_range(0, FRAMES_PER_SET - 1)) : -1;
            for (int i = 0; i < FRAMES_PER_SET; i++)
                send_frame(i == clear_at, pick_sample(), pick_sample());
        end
        no_gaps = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial
    begin
        wipe_shadow();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_overdub_saturation();
        test_odd_settings();
        test_disable_and_clear();
        test_backpressure();
        test_random_phases();

        // Drain: wait for every predicted frame, then let the pipe settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d frame requests (%0d clears) across %0d register settings.",
                 frames_sent, clears_sent, settings_used);
        $display("Checked %0d result frames, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
